FILE: design/crg_pkg.sv
`default_nettype none

package crg_pkg;

  localparam int PIX_BITS = 12;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 48;

  typedef enum logic [CFG_AW-1:0] {
    REG_VIEW_MODE   = 3'd0,
    REG_CENTER      = 3'd1,
    REG_BASIS_U     = 3'd2,
    REG_BASIS_V     = 3'd3,
    REG_BASIS_W     = 3'd4,
    REG_IMAGE_DIMS  = 3'd5,
    REG_WINDOW_DIMS = 3'd6,
    REG_EYE_DIST    = 3'd7
  } cfg_reg_t;

  localparam logic [47:0]           RST_CENTER  = 48'hFF00_0000_0000;
  localparam logic [47:0]           RST_BASIS_U = 48'h0000_0000_4000;
  localparam logic [47:0]           RST_BASIS_V = 48'h0000_4000_0000;
  localparam logic [47:0]           RST_BASIS_W = 48'hC000_0000_0000;
  localparam logic [2*PIX_BITS-1:0] RST_IMAGE   = (2*PIX_BITS)'(1) | ((2*PIX_BITS)'(1) << PIX_BITS);
  localparam logic [31:0]           RST_WINDOW  = 32'h0100_0100;
  localparam logic [31:0]           RST_EYE     = 32'h03E8_0000;

  typedef struct packed {
    logic [PIX_BITS-1:0] pix_col;
    logic [PIX_BITS-1:0] pix_row;
  } ray_req_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } ray_t;

endpackage

`default_nettype wire

FILE: design/camera_ray_generator.sv
`default_nettype none

// Camera ray generator: one pixel request in, one ray out, one ray per clock when the
// output is not stalled. The depth is set by the pixel offset divider (one quotient bit per
// stage), the 31-stage square root and the normalising dividers (OUT_FRAC_BITS + 1 stages),
// which all run even in orthographic mode. A stall while a ray waits at the output holds the
// whole pipeline. Configuration registers are read live by the stages that use them, so
// write them only while the pipeline is empty.
module camera_ray_generator #(
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  crg_pkg::ray_req_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output crg_pkg::ray_t                  out_data,
  input  logic                           cfg_we,
  input  logic [crg_pkg::CFG_AW-1:0]     cfg_addr,
  input  logic [crg_pkg::CFG_DW-1:0]     cfg_wdata
);
  import crg_pkg::*;

  localparam int P    = PIX_BITS;
  localparam int F    = OUT_FRAC_BITS;
  localparam int RS   = 30 - F;
  localparam int TW   = P + 2;
  localparam int MAGW = P + 1;
  localparam int MW1  = 16 + MAGW;
  localparam int NW1  = MW1 + 7;
  localparam int QXW  = (NW1 > 33) ? NW1 : 33;
  localparam int SW   = 50;
  localparam int MW   = 49;
  localparam int NMW  = 30;
  localparam int SQW  = 60;
  localparam int SUMW = 62;
  localparam int RTW  = 31;
  localparam int RRW  = 33;
  localparam int D2W  = F + 1;
  localparam int NUMW = NMW + F + 1;
  localparam int SDL  = 6 + RTW + D2W;
  localparam int LAT  = NW1 + F + 44;
  localparam int V_DN = NW1 + 9 + RTW;

  localparam logic signed [SW-1:0] RND_HALF = SW'(1) << (RS - 1);
  localparam logic signed [SW-1:0] S32_MAX  = SW'(32'h7FFF_FFFF);
  localparam logic signed [SW-1:0] S32_MIN  = ~S32_MAX;
  localparam logic [QXW-1:0]       QPOS_MAX = QXW'(32'h7FFF_FFFF);
  localparam logic [QXW-1:0]       QNEG_MAX = QXW'(33'h0_8000_0000);
  localparam logic [D2W-1:0]       UNIT_Q   = D2W'(1) << F;

  typedef struct packed {
    logic [2:0][31:0] org;
    logic [2:0]       neg;
  } side_t;

  function automatic logic signed [31:0] q30_out(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    logic signed [SW-1:0] s;
    t = v + RND_HALF;
    s = t >>> RS;
    if (s > S32_MAX) return S32_MAX[31:0];
    if (s < S32_MIN) return S32_MIN[31:0];
    return s[31:0];
  endfunction

  // configuration
  logic              view_mode_r;
  logic [47:0]       center_r, basis_u_r, basis_v_r, basis_w_r;
  logic [2*P-1:0]    image_dims_r;
  logic [31:0]       window_dims_r, eye_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_mode_r   <= 1'b0;
      center_r      <= RST_CENTER;
      basis_u_r     <= RST_BASIS_U;
      basis_v_r     <= RST_BASIS_V;
      basis_w_r     <= RST_BASIS_W;
      image_dims_r  <= RST_IMAGE;
      window_dims_r <= RST_WINDOW;
      eye_r         <= RST_EYE;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_VIEW_MODE:   view_mode_r   <= cfg_wdata[0];
        REG_CENTER:      center_r      <= cfg_wdata[47:0];
        REG_BASIS_U:     basis_u_r     <= cfg_wdata[47:0];
        REG_BASIS_V:     basis_v_r     <= cfg_wdata[47:0];
        REG_BASIS_W:     basis_w_r     <= cfg_wdata[47:0];
        REG_IMAGE_DIMS:  image_dims_r  <= cfg_wdata[2*P-1:0];
        REG_WINDOW_DIMS: window_dims_r <= cfg_wdata[31:0];
        REG_EYE_DIST:    eye_r         <= cfg_wdata[31:0];
      endcase
    end
  end

  logic [P-1:0]       img [2];
  logic [15:0]        win [2];
  logic [P-1:0]       pix [2];
  logic signed [15:0] cen [3];
  logic signed [15:0] bu  [3];
  logic signed [15:0] bv  [3];
  logic signed [15:0] bw  [3];

  always_comb begin
    img[0] = image_dims_r[P-1:0];
    img[1] = image_dims_r[2*P-1:P];
    win[0] = window_dims_r[15:0];
    win[1] = window_dims_r[31:16];
    pix[0] = in_data.pix_col;
    pix[1] = in_data.pix_row;
    for (int k = 0; k < 3; k++) begin
      cen[k] = center_r[16*k +: 16];
      bu[k]  = basis_u_r[16*k +: 16];
      bv[k]  = basis_v_r[16*k +: 16];
      bw[k]  = basis_w_r[16*k +: 16];
    end
  end

  // pipeline control: an output stall while a ray is at the output holds every stage
  logic [LAT-1:0] vld_r;
  logic           adv;

  assign adv       = !(vld_r[LAT-1] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // pixel offset: |win * (2p + 1 - img)| * 128 / img, one quotient bit per stage
  logic [P-1:0]   d1_rem_r [2][NW1+1];
  logic [NW1-1:0] d1_w_r   [2][NW1+1];
  logic           d1_neg_r [2][NW1+1];
  logic [MW1-1:0] a_m   [2];
  logic           a_neg [2];

  always_comb begin
    logic signed [TW-1:0] t;
    logic [TW-1:0]        ta;
    for (int a = 0; a < 2; a++) begin
      t        = $signed({1'b0, pix[a], 1'b1}) - $signed({2'b00, img[a]});
      a_neg[a] = t[TW-1];
      ta       = a_neg[a] ? (~t + 1'b1) : t;
      a_m[a]   = {{MAGW{1'b0}}, win[a]} * {{16{1'b0}}, ta[MAGW-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 2; a++) begin
        d1_rem_r[a][0] <= '0;
        d1_w_r[a][0]   <= {a_m[a], 7'b0};
        d1_neg_r[a][0] <= a_neg[a];
      end
    end
  end

  for (genvar a = 0; a < 2; a++) begin : g_ax
    for (genvar j = 0; j < NW1; j++) begin : g_d1
      logic [P:0] t;
      logic       ge;
      assign t  = {d1_rem_r[a][j], d1_w_r[a][j][NW1-1]};
      assign ge = t >= {1'b0, img[a]};
      always_ff @(posedge clk) begin
        if (adv) begin
          d1_rem_r[a][j+1] <= ge ? P'(t - {1'b0, img[a]}) : t[P-1:0];
          d1_w_r[a][j+1]   <= {d1_w_r[a][j][NW1-2:0], ge};
          d1_neg_r[a][j+1] <= d1_neg_r[a][j];
        end
      end
    end
  end

  // saturate and restore the sign; an empty image axis gives no offset
  logic signed [31:0] off_r   [2];
  logic signed [31:0] off_nxt [2];

  always_comb begin
    logic [QXW-1:0] qx;
    for (int a = 0; a < 2; a++) begin
      qx = QXW'(d1_w_r[a][NW1]);
      if (img[a] == '0) begin
        off_nxt[a] = '0;
      end else if (!d1_neg_r[a][NW1]) begin
        off_nxt[a] = (qx > QPOS_MAX) ? S32_MAX[31:0] : qx[31:0];
      end else begin
        off_nxt[a] = (qx > QNEG_MAX) ? S32_MIN[31:0] : (~qx[31:0] + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      off_r <= off_nxt;
    end
  end

  // products, then the Q30 sums
  logic signed [47:0]   pu_r  [3];
  logic signed [47:0]   pv_r  [3];
  logic signed [SW-1:0] pt_r  [3];
  logic signed [SW-1:0] acc_r [3];
  logic signed [32:0]   eye_s;

  assign eye_s = $signed({1'b0, eye_r});

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        pu_r[k]  <= 48'(bu[k]) * 48'(off_r[0]);
        pv_r[k]  <= 48'(bv[k]) * 48'(off_r[1]);
        pt_r[k]  <= view_mode_r ? -(SW'(eye_s) * SW'(bw[k])) : (SW'(cen[k]) <<< 22);
        acc_r[k] <= SW'(pu_r[k]) + SW'(pv_r[k]) + pt_r[k];
      end
    end
  end

  // magnitudes and the orthographic origin
  logic [MW-1:0] nm_r  [4][3];
  side_t         sd_r  [SDL+1];
  side_t         sd0_nxt;
  logic [MW-1:0] mag_nxt [3];

  always_comb begin
    logic [SW-1:0] aa;
    for (int k = 0; k < 3; k++) begin
      sd0_nxt.org[k] = q30_out(acc_r[k]);
      sd0_nxt.neg[k] = acc_r[k][SW-1];
      aa             = acc_r[k][SW-1] ? -acc_r[k] : acc_r[k];
      mag_nxt[k]     = aa[MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_r[0] <= sd0_nxt;
      for (int k = 0; k < 3; k++) begin
        nm_r[0][k] <= mag_nxt[k];
      end
    end
  end

  for (genvar s = 0; s < SDL; s++) begin : g_side
    always_ff @(posedge clk) begin
      if (adv) begin
        sd_r[s+1] <= sd_r[s];
      end
    end
  end

  // left-align the three magnitudes together, two shift levels per stage
  for (genvar s = 0; s < 3; s++) begin : g_nrm
    localparam int SH_HI = 1 << (5 - 2*s);
    localparam int SH_LO = SH_HI / 2;
    logic [MW-1:0] orm0, orm1;
    logic          hi, lo;
    logic [MW-1:0] m1 [3];
    assign orm0 = nm_r[s][0] | nm_r[s][1] | nm_r[s][2];
    assign hi   = ~|orm0[MW-1 -: SH_HI];
    assign orm1 = hi ? (orm0 << SH_HI) : orm0;
    assign lo   = ~|orm1[MW-1 -: SH_LO];
    for (genvar k = 0; k < 3; k++) begin : g_ln
      assign m1[k] = hi ? (nm_r[s][k] << SH_HI) : nm_r[s][k];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int k = 0; k < 3; k++) begin
          nm_r[s+1][k] <= lo ? (m1[k] << SH_LO) : m1[k];
        end
      end
    end
  end

  // squares and their sum
  logic [NMW-1:0]  mg_r [RTW+2][3];
  logic [SQW-1:0]  sq_r [3];
  logic [RRW-1:0]  rt_rem_r  [RTW+1];
  logic [RTW-1:0]  rt_root_r [RTW+1];
  logic [SUMW-1:0] rt_v_r    [RTW+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        mg_r[0][k] <= nm_r[3][k][MW-1 -: NMW];
        sq_r[k]    <= SQW'(nm_r[3][k][MW-1 -: NMW]) * SQW'(nm_r[3][k][MW-1 -: NMW]);
      end
      rt_rem_r[0]  <= '0;
      rt_root_r[0] <= '0;
      rt_v_r[0]    <= SUMW'(sq_r[0]) + SUMW'(sq_r[1]) + SUMW'(sq_r[2]);
    end
  end

  for (genvar i = 0; i < RTW + 1; i++) begin : g_mg
    always_ff @(posedge clk) begin
      if (adv) begin
        mg_r[i+1] <= mg_r[i];
      end
    end
  end

  // integer square root, one root bit per stage
  for (genvar i = 0; i < RTW; i++) begin : g_rt
    logic [RRW+1:0] r4, tr;
    logic           ge;
    assign r4 = {rt_rem_r[i], rt_v_r[i][SUMW-1 -: 2]};
    assign tr = {2'b00, rt_root_r[i], 2'b01};
    assign ge = r4 >= tr;
    always_ff @(posedge clk) begin
      if (adv) begin
        rt_rem_r[i+1]  <= ge ? RRW'(r4 - tr) : r4[RRW-1:0];
        rt_root_r[i+1] <= {rt_root_r[i][RTW-2:0], ge};
        rt_v_r[i+1]    <= rt_v_r[i] << 2;
      end
    end
  end

  // normalise: (mag * 2^F + n/2) / n, one quotient bit per stage
  logic [RTW-1:0] dv_rem_r [D2W+1][3];
  logic [D2W-1:0] dv_w_r   [D2W+1][3];
  logic [RTW-1:0] dv_n_r   [D2W+1];

  always_ff @(posedge clk) begin
    logic [NUMW-1:0] num;
    if (adv) begin
      dv_n_r[0] <= rt_root_r[RTW];
      for (int k = 0; k < 3; k++) begin
        num            = (NUMW'(mg_r[RTW+1][k]) << F) + NUMW'(rt_root_r[RTW] >> 1);
        dv_rem_r[0][k] <= RTW'(num[NUMW-1:F+1]);
        dv_w_r[0][k]   <= num[F:0];
      end
    end
  end

  for (genvar j = 0; j < D2W; j++) begin : g_dv
    for (genvar k = 0; k < 3; k++) begin : g_ln
      logic [RTW:0] t;
      logic         ge;
      assign t  = {dv_rem_r[j][k], dv_w_r[j][k][F]};
      assign ge = t >= {1'b0, dv_n_r[j]};
      always_ff @(posedge clk) begin
        if (adv) begin
          dv_rem_r[j+1][k] <= ge ? RTW'(t - {1'b0, dv_n_r[j]}) : t[RTW-1:0];
          dv_w_r[j+1][k]   <= {dv_w_r[j][k][F-1:0], ge};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_n_r[j+1] <= dv_n_r[j];
      end
    end
  end

  // select by projection mode and register the ray
  ray_t res_nxt, res_r;

  always_comb begin
    logic signed [31:0] org [3];
    logic signed [31:0] dir [3];
    logic [31:0]        q;
    for (int k = 0; k < 3; k++) begin
      q = 32'(dv_w_r[D2W][k]);
      if (view_mode_r) begin
        org[k] = q30_out(SW'(cen[k]) <<< 22);
        if (dv_n_r[D2W] == '0) begin
          dir[k] = '0;
        end else begin
          dir[k] = sd_r[SDL].neg[k] ? (~q + 1'b1) : q;
        end
      end else begin
        org[k] = sd_r[SDL].org[k];
        dir[k] = q30_out(-(SW'(bw[k]) <<< 16));
      end
    end
    res_nxt.origin_x = org[0];
    res_nxt.origin_y = org[1];
    res_nxt.origin_z = org[2];
    res_nxt.dir_x    = dir[0];
    res_nxt.dir_y    = dir[1];
    res_nxt.dir_z    = dir[2];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_data = res_r;

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAT-1] && out_stall |-> in_stall)
    else $error("input taken while the output is held");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_r[0])
    else $error("accepted request did not enter the pipeline");

  a_root_normalised: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[V_DN] && (rt_root_r[RTW] != '0) |-> (rt_root_r[RTW][RTW-1:RTW-2] != 2'b00))
    else $error("square root of a normalised vector below range");

  a_unit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAT-2] && (dv_n_r[D2W] != '0) |->
      (dv_w_r[D2W][0] <= UNIT_Q) && (dv_w_r[D2W][1] <= UNIT_Q) && (dv_w_r[D2W][2] <= UNIT_Q))
    else $error("direction component exceeds unit length");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import crg_pkg::*;

  localparam int DRAIN_CYCLES = 120;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ray_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ray_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  camera_ray_generator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // shadow copy of the camera registers
  logic        cam_persp;
  logic [47:0] cam_center, cam_u, cam_v, cam_w;
  logic [23:0] cam_image;
  logic [31:0] cam_window, cam_eye;

  ray_req_t pending_pix[$];
  ray_t     expected_rays[$];
  int errors = 0;
  int req_count = 0;
  int ray_count = 0;
  int persp_count = 0;
  bit steady = 0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint lane(logic [47:0] r, int k);
    return longint'($signed(r[16*k +: 16]));
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q30 to Q16.16, round half up, saturate
  function automatic logic [31:0] q30_to_out(longint v);
    longint r;
    r = (v + 64'sd8192) >>> 14;
    return 32'(sat32(r));
  endfunction

  function automatic longint window_offset(longint p, longint img, longint win);
    longint num;
    if (img == 0) return 0;
    num = win * (2 * p + 1 - img) * 256;
    return sat32(num / (2 * img));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic ray_t trace_ray(ray_req_t rq);
    ray_t r;
    longint ox, oy, c, acc, d;
    longint unsigned mag[3], mx, sum, n, q;
    bit neg[3];
    int b;
    logic [31:0] org[3], dir[3];
    ox = window_offset(longint'(rq.pix_col), longint'(cam_image[11:0]),
                       longint'(cam_window[15:0]));
    oy = window_offset(longint'(rq.pix_row), longint'(cam_image[23:12]),
                       longint'(cam_window[31:16]));
    if (!cam_persp) begin
      for (int k = 0; k < 3; k++) begin
        acc = lane(cam_u, k) * ox + lane(cam_v, k) * oy + lane(cam_center, k) * (64'sd1 << 22);
        org[k] = q30_to_out(acc);
        dir[k] = q30_to_out(-lane(cam_w, k) * 65536);
      end
    end else begin
      mx = 0;
      sum = 0;
      for (int k = 0; k < 3; k++) begin
        c = -longint'(cam_eye) * lane(cam_w, k) + lane(cam_u, k) * ox + lane(cam_v, k) * oy;
        neg[k] = c < 0;
        mag[k] = neg[k] ? longint'(-c) : c;
        if (mag[k] > mx) mx = mag[k];
        org[k] = q30_to_out(lane(cam_center, k) * (64'sd1 << 22));
      end
      if (mx != 0) begin
        b = 0;
        while (b < 63 && (mx >> (b + 1)) != 0) b++;
        for (int k = 0; k < 3; k++) begin
          if (b > 29) mag[k] >>= (b - 29);
          else mag[k] <<= (29 - b);
          sum += mag[k] * mag[k];
        end
      end
      n = int_sqrt(sum);
      for (int k = 0; k < 3; k++) begin
        d = 0;
        if (n != 0) begin
          q = ((mag[k] << 16) + (n >> 1)) / n;
          d = neg[k] ? -longint'(q) : longint'(q);
        end
        dir[k] = 32'(sat32(d));
      end
    end
    r.origin_x = org[0]; r.origin_y = org[1]; r.origin_z = org[2];
    r.dir_x = dir[0]; r.dir_y = dir[1]; r.dir_z = dir[2];
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch ray %0d %s: got %h expected %h", ray_count, field, got, want);
    errors++;
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_rays.push_back(trace_ray(in_data));
        req_count++;
        if (cam_persp) persp_count++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_pix.size() > 0 && (steady || $urandom_range(99) >= 9)) begin
          in_data <= pending_pix.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ray monitor and receiver stall
  int hold_left = 0;
  bit held = 0;
  always @(posedge clk) begin
    ray_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_rays.size() == 0) begin
          $display("unexpected ray %0d", ray_count);
          errors++;
        end else begin
          want = expected_rays.pop_front();
          if (out_data.origin_x !== want.origin_x)
            report_mismatch("origin_x", out_data.origin_x, want.origin_x);
          if (out_data.origin_y !== want.origin_y)
            report_mismatch("origin_y", out_data.origin_y, want.origin_y);
          if (out_data.origin_z !== want.origin_z)
            report_mismatch("origin_z", out_data.origin_z, want.origin_z);
          if (out_data.dir_x !== want.dir_x) report_mismatch("dir_x", out_data.dir_x, want.dir_x);
          if (out_data.dir_y !== want.dir_y) report_mismatch("dir_y", out_data.dir_y, want.dir_y);
          if (out_data.dir_z !== want.dir_z) report_mismatch("dir_z", out_data.dir_z, want.dir_z);
        end
        ray_count++;
      end
      // hold off once for a long stretch so the pipeline backs up
      if (!held && ray_count == 300) begin
        held = 1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady && $urandom_range(99) < 9;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[camera_ray_generator] ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [47:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_VIEW_MODE:   cam_persp = val[0];
      REG_CENTER:      cam_center = val;
      REG_BASIS_U:     cam_u = val;
      REG_BASIS_V:     cam_v = val;
      REG_BASIS_W:     cam_w = val;
      REG_IMAGE_DIMS:  cam_image = val[23:0];
      REG_WINDOW_DIMS: cam_window = val[31:0];
      default:         cam_eye = val[31:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_pix.size() > 0 || in_valid || expected_rays.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_pix(int col, int row);
    ray_req_t rq;
    rq.pix_col = col[11:0];
    rq.pix_row = row[11:0];
    pending_pix.push_back(rq);
  endtask

  task automatic directed_set();
    add_pix(0, 0);
    add_pix(4095, 4095);
    add_pix(0, 4095);
    add_pix(4095, 0);
    add_pix(1, 1);
    add_pix(2048, 2048);
    add_pix(12'hAAA, 12'h555);
    add_pix(12'h555, 12'hAAA);
  endtask

  // random basis lane: mostly unit-ish, sometimes anything
  function automatic logic [47:0] rand_basis();
    logic [47:0] v;
    v = 48'({$urandom(), $urandom()});
    if ($urandom_range(3) != 0)
      for (int k = 0; k < 3; k++) v[16*k +: 16] = 16'($signed($urandom_range(32768)) - 16384);
    return v;
  endfunction

  task automatic random_phase(int n);
    int w, h;
    logic [47:0] img;
    write_reg(REG_VIEW_MODE, 48'($urandom_range(1)));
    write_reg(REG_CENTER, 48'({$urandom(), $urandom()}));
    write_reg(REG_BASIS_U, rand_basis());
    write_reg(REG_BASIS_V, rand_basis());
    write_reg(REG_BASIS_W, rand_basis());
    if ($urandom_range(4) == 0) img = 48'({$urandom(), $urandom()});
    else img = 48'({12'($urandom_range(1, 64)), 12'($urandom_range(1, 64))});
    write_reg(REG_IMAGE_DIMS, img);
    w = int'(img[11:0]);
    h = int'(img[23:12]);
    write_reg(REG_WINDOW_DIMS, $urandom_range(1) ? 48'($urandom()) : 48'($urandom_range(4096)));
    write_reg(REG_EYE_DIST, 48'($urandom()));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) != 0 && w > 0 && h > 0)
        add_pix($urandom_range(w - 1), $urandom_range(h - 1));
      else
        add_pix($urandom_range(4095), $urandom_range(4095));
    end
    drain();
  endtask

  initial begin
    cam_persp = 1'b0;
    cam_center = RST_CENTER;
    cam_u = RST_BASIS_U;
    cam_v = RST_BASIS_V;
    cam_w = RST_BASIS_W;
    cam_image = RST_IMAGE;
    cam_window = RST_WINDOW;
    cam_eye = RST_EYE;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset camera, orthographic then perspective
    directed_set();
    drain();
    write_reg(REG_VIEW_MODE, 48'd1);
    directed_set();
    drain();
    // zero image size in both modes
    write_reg(REG_IMAGE_DIMS, 48'd0);
    directed_set();
    drain();
    write_reg(REG_VIEW_MODE, 48'd0);
    add_pix(7, 9);
    drain();
    // extremes: saturating origins, largest window and distance
    write_reg(REG_CENTER, 48'h7FFF_8000_7FFF);
    write_reg(REG_BASIS_U, 48'h8000_7FFF_8000);
    write_reg(REG_BASIS_V, 48'h7FFF_7FFF_8000);
    write_reg(REG_BASIS_W, 48'h8000_8000_8000);
    write_reg(REG_IMAGE_DIMS, 48'hFFF_FFF);
    write_reg(REG_WINDOW_DIMS, 48'hFFFF_FFFF);
    write_reg(REG_EYE_DIST, 48'hFFFF_FFFF);
    directed_set();
    drain();
    write_reg(REG_VIEW_MODE, 48'd1);
    directed_set();
    drain();
    // zero perspective vector: no distance, no offsets
    write_reg(REG_EYE_DIST, 48'd0);
    write_reg(REG_IMAGE_DIMS, 48'd0);
    add_pix(100, 200);
    add_pix(4095, 0);
    drain();

    for (int p = 0; p < 11; p++) begin
      steady = (p == 3);
      random_phase(120);
    end
    steady = 0;

    $display("%0d requests (%0d perspective), %0d rays checked", req_count, persp_count,
             ray_count);
    $display("directed extremes, zero image and zero vector cases, 11 random camera setups");
    if (errors == 0) begin
      $display("[camera_ray_generator] OK");
    end else begin
      $display("[camera_ray_generator] ERROR");
    end
    $finish;
  end

endmodule
